[design/msq_pkg.sv]
// ----------------------------------------------------------------------------
// msq_pkg: shared types, constants and table functions for the scale quantizer.
// Holds the scale interval table, the white-key mask and small helpers for
// dividing a MIDI key by a scale length without a divider.
// ----------------------------------------------------------------------------
package msq_pkg;

    localparam int NOTE_MAX    = 127;
    localparam int OCTAVE      = 12;
    localparam int SCALE_COUNT = 21;
    localparam int NUM_IV      = 12;

    // Configuration register indexes.
    localparam logic [1:0] REG_SCALE_TYPE     = 2'd0;
    localparam logic [1:0] REG_ROOT_NOTE      = 2'd1;
    localparam logic [1:0] REG_WHITE_KEY_SNAP = 2'd2;
    localparam logic [1:0] REG_COMPACT_MODE   = 2'd3;

    // Scale selector of the chromatic scale.
    localparam logic [4:0] SCALE_CHROMATIC = 5'd0;

    // Configuration reset values.
    localparam logic [4:0] RESET_SCALE_TYPE = 5'd0;
    localparam logic [6:0] RESET_ROOT_NOTE  = 7'd60;
    localparam logic       RESET_SNAP       = 1'b1;
    localparam logic       RESET_COMPACT    = 1'b0;

    // Bit i is set when pitch class i is a white key.
    localparam logic [11:0] WHITE_KEYS = 12'b1010_1011_0101;

    localparam logic [3:0] SCALE_LEN [SCALE_COUNT] = '{
        4'd12, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd6, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd7, 4'd6, 4'd8, 4'd6, 4'd5, 4'd5, 4'd7, 4'd7
    };

    // Interval sets, padded with zeros beyond the scale length.
    localparam logic [3:0] SCALE_IV [SCALE_COUNT][NUM_IV] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd4, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd7, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd4, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    // Best candidate found so far in the nearest-note search.
    typedef struct packed {
        logic       found;
        logic [6:0] note;
        logic [6:0] distance;
    } msq_best_t;

    // One request as it travels through the search stages.
    typedef struct packed {
        logic [6:0] key;
        logic [6:0] n;
        logic [6:0] cnote;
        logic       csat;
        msq_best_t  best;
    } msq_item_t;

    // Number of intervals in a scale; unknown selectors give an empty scale.
    function automatic logic [3:0] scale_len(input logic [4:0] sel);
        if (sel < 5'(SCALE_COUNT)) begin
            return SCALE_LEN[sel];
        end
        return 4'd0;
    endfunction

    // Interval number idx of a scale.
    function automatic logic [3:0] scale_iv(input logic [4:0] sel, input logic [3:0] idx);
        if ((sel < 5'(SCALE_COUNT)) && (idx < 4'(NUM_IV))) begin
            return SCALE_IV[sel][idx];
        end
        return 4'd0;
    endfunction

    // Quotient of a 7-bit key by a scale length, by reciprocal multiplication.
    // The reciprocals are exact for every key up to 127.
    function automatic logic [4:0] div_by_len(input logic [6:0] key, input logic [3:0] len);
        logic [14:0] prod;
        prod = '0;
        case (len)
            4'd5:    prod = 15'(15'(key) * 15'd205) >> 10;
            4'd6:    prod = 15'(15'(key) * 15'd171) >> 10;
            4'd7:    prod = 15'(15'(key) * 15'd147) >> 10;
            4'd8:    prod = 15'(key) >> 3;
            4'd12:   prod = 15'(15'(key) * 15'd171) >> 11;
            default: prod = '0;
        endcase
        return prod[4:0];
    endfunction

    // Quotient times scale length, as shifts and adds.
    function automatic logic [8:0] mul_len(input logic [4:0] q, input logic [3:0] len);
        logic [8:0] qw;
        logic [8:0] res;
        qw  = 9'(q);
        res = '0;
        case (len)
            4'd5:    res = (qw << 2) + qw;
            4'd6:    res = (qw << 2) + (qw << 1);
            4'd7:    res = (qw << 3) - qw;
            4'd8:    res = qw << 3;
            4'd12:   res = (qw << 3) + (qw << 2);
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[design/midi_scale_quantizer_top.sv]
// ----------------------------------------------------------------------------
// midi_scale_quantizer_top: MIDI note to musical scale quantizer.
// Maps a played key to the nearest note of a selected scale, or maps a key
// index to a scale degree in compact mode.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one key value per request and the m_ channel returns
//   one note and a saturation flag for each, in order. Both use valid/ready.
//   The cfg channel writes the scale type, root note, white-key snap and
//   compact mode registers; it is always ready, and writes must be made while
//   no request is in flight, which the block itself does not enforce.
//   Throughput is one request per cycle while the receiver keeps m_ready high.
//   A request passes through an input register, a snap and divide stage,
//   five search stages (one per octave offset from -2 to +2, each scoring
//   twelve candidates), and the output register before it appears on m_valid.
//   Each stage holds its own valid bit and moves on whenever the next stage
//   is empty or moving, so bubbles are squeezed out. When the receiver stalls
//   the pipeline fills and then s_ready drops; nothing is lost or repeated.
//   Reset empties the pipeline and loads the register defaults: chromatic
//   scale, root note 60, white-key snap on, compact mode off.
// ----------------------------------------------------------------------------
module midi_scale_quantizer_top (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [6:0] s_key_value,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_note_out,
    output logic       m_saturated,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_addr,
    input  logic [6:0] cfg_data
);

    localparam int NUM_SEARCH = 5;
    localparam int NUM_STAGES = NUM_SEARCH + 3;
    localparam int OUT_STAGE  = NUM_STAGES - 1;

    // Configuration registers.
    logic [4:0] cfg_scale_reg;
    logic [6:0] cfg_root_reg;
    logic       cfg_snap_reg;
    logic       cfg_compact_reg;

    // Pipeline control.
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    // Stage payloads.
    logic [6:0]          key_a_reg;
    logic [6:0]          key_b_reg;
    logic [6:0]          n_b_reg;
    logic [4:0]          q_b_reg;
    logic [3:0]          r_b_reg;
    msq_pkg::msq_item_t  item_reg    [NUM_SEARCH];
    msq_pkg::msq_item_t  item_src    [NUM_SEARCH];
    msq_pkg::msq_item_t  item_next   [NUM_SEARCH];
    msq_pkg::msq_best_t  search_best [NUM_SEARCH];
    logic [6:0]          note_reg;
    logic                sat_reg;

    // Combinational values between stages.
    logic [3:0] len;
    logic [4:0] q12;
    logic [3:0] pc;
    logic [6:0] n_next;
    logic [4:0] q_next;
    logic [3:0] r_next;
    logic [8:0] csum;
    logic [6:0] note_next;
    logic       sat_next;

    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_scale_reg   <= msq_pkg::RESET_SCALE_TYPE;
            cfg_root_reg    <= msq_pkg::RESET_ROOT_NOTE;
            cfg_snap_reg    <= msq_pkg::RESET_SNAP;
            cfg_compact_reg <= msq_pkg::RESET_COMPACT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                msq_pkg::REG_SCALE_TYPE:     cfg_scale_reg   <= cfg_data[4:0];
                msq_pkg::REG_ROOT_NOTE:      cfg_root_reg    <= cfg_data;
                msq_pkg::REG_WHITE_KEY_SNAP: cfg_snap_reg    <= cfg_data[0];
                msq_pkg::REG_COMPACT_MODE:   cfg_compact_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[OUT_STAGE] = !v_reg[OUT_STAGE] || m_ready;
        for (int i = OUT_STAGE - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i + 1];
        end
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i - 1];
                end
            end
        end
    end

    // Snap to a white key and split the key by the scale length.
    always_comb begin
        len    = msq_pkg::scale_len(cfg_scale_reg);
        q12    = msq_pkg::div_by_len(key_a_reg, 4'(msq_pkg::OCTAVE));
        pc     = 4'(key_a_reg - 7'(msq_pkg::mul_len(q12, 4'(msq_pkg::OCTAVE))));
        n_next = (cfg_snap_reg && !msq_pkg::WHITE_KEYS[pc]) ? key_a_reg + 7'd1 : key_a_reg;
        q_next = msq_pkg::div_by_len(key_a_reg, len);
        r_next = 4'(key_a_reg - 7'(msq_pkg::mul_len(q_next, len)));
    end

    // Compact mode degree note, clamped at the top of the MIDI range.
    always_comb begin
        if (len == 4'd0) begin
            csum = {2'b00, cfg_root_reg} + {2'b00, key_b_reg};
        end else begin
            csum = {2'b00, cfg_root_reg}
                 + {5'b00000, msq_pkg::scale_iv(cfg_scale_reg, r_b_reg)}
                 + msq_pkg::mul_len(q_b_reg, 4'(msq_pkg::OCTAVE));
        end
        item_src[0].key   = key_b_reg;
        item_src[0].n     = n_b_reg;
        item_src[0].csat  = csum > 9'(msq_pkg::NOTE_MAX);
        item_src[0].cnote = item_src[0].csat ? 7'(msq_pkg::NOTE_MAX) : csum[6:0];
        item_src[0].best  = '0;
    end

    // Search stages, lowest octave offset first.
    for (genvar j = 0; j < NUM_SEARCH; j++) begin : g_search
        localparam int OFS = msq_pkg::OCTAVE * (j - 2);
        logic signed [8:0] base;

        assign base = signed'({2'b00, cfg_root_reg}) + signed'(9'(OFS));

        if (j > 0) begin : g_chain
            assign item_src[j] = item_reg[j - 1];
        end

        msq_search u_search (
            .scale_type (cfg_scale_reg),
            .base       (base),
            .n          (item_src[j].n),
            .best_in    (item_src[j].best),
            .best_out   (search_best[j])
        );

        always_comb begin
            item_next[j]      = item_src[j];
            item_next[j].best = search_best[j];
        end
    end

    // Final selection among pass-through, search, snapped-note fallback and compact results.
    always_comb begin
        sat_next = 1'b0;
        if (cfg_compact_reg) begin
            note_next = item_reg[NUM_SEARCH - 1].cnote;
            sat_next  = item_reg[NUM_SEARCH - 1].csat;
        end else if (cfg_scale_reg == msq_pkg::SCALE_CHROMATIC) begin
            note_next = item_reg[NUM_SEARCH - 1].key;
        end else if (item_reg[NUM_SEARCH - 1].best.found) begin
            note_next = item_reg[NUM_SEARCH - 1].best.note;
        end else begin
            note_next = item_reg[NUM_SEARCH - 1].n;
        end
    end

    // Payload registers follow their stage enables.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            key_a_reg <= s_key_value;
        end
        if (en[1]) begin
            key_b_reg <= key_a_reg;
            n_b_reg   <= n_next;
            q_b_reg   <= q_next;
            r_b_reg   <= r_next;
        end
        for (int i = 0; i < NUM_SEARCH; i++) begin
            if (en[i + 2]) begin
                item_reg[i] <= item_next[i];
            end
        end
        if (en[OUT_STAGE]) begin
            note_reg <= note_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid     = v_reg[OUT_STAGE];
    assign m_note_out  = note_reg;
    assign m_saturated = sat_reg;

`ifndef SYNTHESIS
    // A saturated result always carries the clamped top note.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_note_out == 7'(msq_pkg::NOTE_MAX))
        else $error("saturated result without clamped note");

    // The compact stage clamps consistently before the search stages.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[2] && item_reg[0].csat |-> item_reg[0].cnote == 7'(msq_pkg::NOTE_MAX))
        else $error("compact saturation flag and note disagree");

    // A full pipeline behind a stalled output takes no new request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg) && !m_ready |-> !s_ready)
        else $error("request accepted into a full stalled pipeline");

    // A stalled result stays in the output stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[OUT_STAGE] && !m_ready |=> v_reg[OUT_STAGE] && $stable(note_reg))
        else $error("stalled result lost from output stage");
`endif

endmodule

[design/msq_search.sv]
// ----------------------------------------------------------------------------
// msq_search: one octave of the nearest-scale-note search.
// Scores the twelve candidates base + interval of one octave offset against
// the note and merges the nearest one with the best of the lower octaves.
// ----------------------------------------------------------------------------
module msq_search (
    input  logic [4:0]          scale_type,
    input  logic signed [8:0]   base,
    input  logic [6:0]          n,
    input  msq_pkg::msq_best_t  best_in,
    output msq_pkg::msq_best_t  best_out
);

    // Keep the left operand on equal distance, so the lower note wins.
    function automatic msq_pkg::msq_best_t pick(input msq_pkg::msq_best_t a,
                                                input msq_pkg::msq_best_t b);
        if (!b.found) begin
            return a;
        end
        if (!a.found) begin
            return b;
        end
        if (b.distance < a.distance) begin
            return b;
        end
        return a;
    endfunction

    logic [3:0]          len;
    logic signed [8:0]   c_val [msq_pkg::NUM_IV];
    logic signed [8:0]   diff  [msq_pkg::NUM_IV];
    msq_pkg::msq_best_t  cand  [msq_pkg::NUM_IV];
    msq_pkg::msq_best_t  lvl1  [6];
    msq_pkg::msq_best_t  lvl2  [3];
    msq_pkg::msq_best_t  lvl3;
    msq_pkg::msq_best_t  lvl4;

    assign len = msq_pkg::scale_len(scale_type);

    // Score each candidate of this octave; out-of-range notes drop out.
    always_comb begin
        for (int i = 0; i < msq_pkg::NUM_IV; i++) begin
            c_val[i] = base + signed'({5'b00000, msq_pkg::scale_iv(scale_type, 4'(i))});
            diff[i]  = signed'({2'b00, n}) - c_val[i];
            cand[i].found    = (4'(i) < len) && (c_val[i] >= 0) &&
                               (c_val[i] <= 9'(msq_pkg::NOTE_MAX));
            cand[i].note     = c_val[i][6:0];
            cand[i].distance = (diff[i] < 0) ? 7'(-diff[i]) : diff[i][6:0];
        end
    end

    // Ordered reduction tree; candidates stand in ascending note order.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            lvl1[i] = pick(cand[2 * i], cand[2 * i + 1]);
        end
        for (int i = 0; i < 3; i++) begin
            lvl2[i] = pick(lvl1[2 * i], lvl1[2 * i + 1]);
        end
        lvl3     = pick(lvl2[0], lvl2[1]);
        lvl4     = pick(lvl3, lvl2[2]);
        best_out = pick(best_in, lvl4);
    end

endmodule

[tb/sv/msq_note_checker.sv]
// ----------------------------------------------------------------------------
// msq_note_checker: result predictor and comparator for the scale quantizer.
// Tracks the configuration writes, predicts the note and saturation flag for
// every accepted request, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module msq_note_checker (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [6:0] s_key_value,

    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [6:0] m_note_out,
    input  logic       m_saturated,

    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_addr,
    input  logic [6:0] cfg_data,

    output int         fail_count,
    output int         pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SCALES = 21;

    // Pitch classes of each scale relative to the root, bit i for interval i.
    // The intervals of a scale are its set bits in ascending order.
    localparam logic [11:0] SCALE_PC_MASK [NUM_SCALES] = '{
        12'hFFF, 12'hAB5, 12'h5AD, 12'h9AD, 12'hAAD, 12'h295, 12'h4A9,
        12'h4E9, 12'h6AD, 12'h5AB, 12'hAD5, 12'h6B5, 12'h56B, 12'h5B3,
        12'h555, 12'hB6D, 12'h29D, 12'h18D, 12'h4A3, 12'h9B3, 12'h55B
    };

    // Pitch classes that fall on white keys.
    localparam logic [11:0] WHITE_PC_MASK = 12'hAB5;

    // Register values after reset.
    localparam logic [4:0] INIT_SCALE   = 5'd0;
    localparam logic [6:0] INIT_ROOT    = 7'd60;
    localparam logic       INIT_SNAP    = 1'b1;
    localparam logic       INIT_COMPACT = 1'b0;

    typedef struct packed {
        logic [6:0] key;
        logic [6:0] note;
        logic       sat;
    } note_expect_t;

    logic [4:0]   scale_sel;
    logic [6:0]   root_reg;
    logic         snap_on;
    logic         compact_on;
    note_expect_t expected_notes [$];

    // Works out the note and saturation flag for one key under the
    // current register settings.
    function automatic note_expect_t predict_note(input logic [6:0] key);
        note_expect_t res;
        logic [11:0]  mask;
        int           len;
        int           q;
        int           r;
        int           iv;
        int           seen;
        int           n;
        int           c;
        int           d;
        int           sum;
        int           best;
        int           best_d;
        bit           found;

        res.key  = key;
        res.note = '0;
        res.sat  = 1'b0;
        mask     = (scale_sel < NUM_SCALES) ? SCALE_PC_MASK[scale_sel] : 12'h000;
        len      = $countones(mask);

        if (compact_on) begin
            // Key index picks a scale degree and an octave above the root.
            if (len == 0) begin
                sum = int'(root_reg) + int'(key);
            end else begin
                q    = int'(key) / len;
                r    = int'(key) % len;
                iv   = 0;
                seen = 0;
                for (int i = 0; i < 12; i++) begin
                    if (mask[i]) begin
                        if (seen == r) begin
                            iv = i;
                        end
                        seen++;
                    end
                end
                sum = int'(root_reg) + iv + 12 * q;
            end
            if (sum > 127) begin
                sum     = 127;
                res.sat = 1'b1;
            end
            res.note = sum[6:0];
        end else if (scale_sel == msq_pkg::SCALE_CHROMATIC) begin
            res.note = key;
        end else begin
            // Optional snap to a white key, then nearest in-range candidate,
            // with ties going to the lower note.
            n = int'(key);
            if (snap_on && !WHITE_PC_MASK[n % 12]) begin
                n = n + 1;
            end
            found  = 1'b0;
            best   = 0;
            best_d = 0;
            for (int k = -2; k <= 2; k++) begin
                for (int i = 0; i < 12; i++) begin
                    if (mask[i]) begin
                        c = int'(root_reg) + i + 12 * k;
                        if (c >= 0 && c <= 127) begin
                            d = (n > c) ? n - c : c - n;
                            if (!found || d < best_d || (d == best_d && c < best)) begin
                                found  = 1'b1;
                                best   = c;
                                best_d = d;
                            end
                        end
                    end
                end
            end
            res.note = found ? best[6:0] : n[6:0];
        end
        return res;
    endfunction

    // Register shadow, prediction on each request, comparison on each result.
    always @(posedge aclk) begin
        note_expect_t exp_item;
        bit           bad;

        if (!aresetn) begin
            scale_sel  <= INIT_SCALE;
            root_reg   <= INIT_ROOT;
            snap_on    <= INIT_SNAP;
            compact_on <= INIT_COMPACT;
            expected_notes.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    msq_pkg::REG_SCALE_TYPE:     scale_sel  <= cfg_data[4:0];
                    msq_pkg::REG_ROOT_NOTE:      root_reg   <= cfg_data;
                    msq_pkg::REG_WHITE_KEY_SNAP: snap_on    <= cfg_data[0];
                    msq_pkg::REG_COMPACT_MODE:   compact_on <= cfg_data[0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (expected_notes.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual note %0d sat %0d",
                             $time, m_note_out, m_saturated);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_item = expected_notes.pop_front();
                    bad      = 1'b0;
                    if (m_note_out !== exp_item.note) begin
                        $display("%0t: key %0d note_out: expected %0d, actual %0d",
                                 $time, exp_item.key, exp_item.note, m_note_out);
                        bad = 1'b1;
                    end
                    if (m_saturated !== exp_item.sat) begin
                        $display("%0t: key %0d saturated: expected %0d, actual %0d",
                                 $time, exp_item.key, exp_item.sat, m_saturated);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        fail_count <= fail_count + 1;
                    end
                end
            end

            if (s_valid && s_ready) begin
                expected_notes.push_back(predict_note(s_key_value));
            end

            pending_count <= expected_notes.size();
        end
    end

endmodule

[tb/sv/tb_midi_scale_quantizer_top.sv]
// ----------------------------------------------------------------------------
// tb_midi_scale_quantizer_top: regression bench for the scale quantizer.
// Drives directed and random key requests through a series of register
// settings with bursty input and a stalling receiver; the checker predicts
// and compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_midi_scale_quantizer_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 20;
    localparam int PHASE_KEYS    = 50;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [6:0] s_key_value = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [6:0] m_note_out;
    logic       m_saturated;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_addr    = '0;
    logic [6:0] cfg_data    = '0;

    int         fail_count;
    int         pending_count;
    int         burst_left    = 0;
    int         idle_cycles   = 0;
    int         stall_left    = 0;
    int         stall_mode    = 0;
    logic [7:0] pattern_count = '0;

    midi_scale_quantizer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_value (s_key_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_note_out  (m_note_out),
        .m_saturated (m_saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data)
    );

    msq_note_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key_value   (s_key_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_note_out    (m_note_out),
        .m_saturated   (m_saturated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver: switches between always ready, coin flip, mostly stalled
    // and a fixed periodic stall, each for a random stretch of cycles.
    always @(posedge aclk) begin
        pattern_count <= pattern_count + 8'd1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (pattern_count[2:0] > 3'd2);
        endcase
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("midi_scale_quantizer_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one key request, opening a new burst after a random gap when
    // the current burst is used up. Valid stays high on return.
    task automatic send_key(input logic [6:0] key);
        int gap;

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid     <= 1'b1;
        s_key_value <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // Stops sending and waits until every request has returned its result.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Writes all four registers once the block has gone idle.
    task automatic apply_config(input logic [4:0] scale, input logic [6:0] root,
                                input logic snap, input logic compact);
        logic [6:0] vals  [4];
        logic [1:0] addrs [4];

        wait_for_results();
        vals  = '{7'(scale), root, 7'(snap), 7'(compact)};
        addrs = '{msq_pkg::REG_SCALE_TYPE, msq_pkg::REG_ROOT_NOTE,
                  msq_pkg::REG_WHITE_KEY_SNAP, msq_pkg::REG_COMPACT_MODE};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random key, with the range ends favored.
    function automatic logic [6:0] random_key();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 7'd127 : 7'd0;
        end
        return 7'($urandom_range(0, 127));
    endfunction

    initial begin
        logic [4:0] scale;
        logic [6:0] root;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: chromatic scale passes keys through.
        send_key(7'd0);
        send_key(7'd127);
        send_key(7'd85);

        // Major scale at middle C with snapping, black key goes up.
        apply_config(5'd1, 7'd60, 1'b1, 1'b0);
        send_key(7'd61);
        send_key(7'd0);
        send_key(7'd127);

        // Root 0 without snap: equal distance goes to the lower note and
        // candidates below zero are dropped.
        apply_config(5'd1, 7'd0, 1'b0, 1'b0);
        send_key(7'd1);
        send_key(7'd127);

        // Root at the top: candidates above 127 are dropped.
        apply_config(5'd20, 7'd127, 1'b0, 1'b0);
        send_key(7'd0);
        send_key(7'd64);

        // Unknown scale selector in quantize mode returns the snapped note.
        apply_config(5'd31, 7'd5, 1'b1, 1'b0);
        send_key(7'd1);
        send_key(7'd126);

        // Unknown scale selector in compact mode adds the key to the root.
        apply_config(5'd25, 7'd127, 1'b0, 1'b1);
        send_key(7'd0);
        send_key(7'd1);

        // Chromatic compact mode just below and just past the clamp.
        apply_config(5'd0, 7'd100, 1'b1, 1'b1);
        send_key(7'd27);
        send_key(7'd28);

        // Shortest scale and the longest non-chromatic one in compact mode.
        apply_config(5'd5, 7'd127, 1'b1, 1'b1);
        send_key(7'd0);
        send_key(7'd127);
        apply_config(5'd15, 7'd0, 1'b0, 1'b1);
        send_key(7'd127);
        send_key(7'd7);

        // Random settings, each followed by a run of random keys.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            scale = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(21, 31))
                                                : 5'($urandom_range(0, 20));
            case ($urandom_range(0, 5))
                0:       root = 7'd0;
                1:       root = 7'd127;
                default: root = 7'($urandom_range(0, 127));
            endcase
            apply_config(scale, root, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (int i = 0; i < PHASE_KEYS; i++) begin
                send_key(random_key());
            end
        end

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("midi_scale_quantizer_top regression: pass");
        end else begin
            $display("midi_scale_quantizer_top regression: fail");
        end
        $finish;
    end

endmodule
